// ===== hw/rtl/sphkn_pkg.sv =====
// sphkn_pkg: shared constants, types and state encodings of the SPH neighbour sum core.
// Used by every module of the block; no dependencies.
`default_nettype none
package sphkn_pkg;

  localparam int MAX_NEIGHBOURS = 1024;
  localparam int COUNT_W        = 11;
  localparam logic [COUNT_W-1:0] COUNT_CAP =
    COUNT_W'((MAX_NEIGHBOURS < 2047) ? MAX_NEIGHBOURS : 2047);

  localparam int REG_W   = 24;
  localparam int SUM_W   = 48;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [2:0] IDX_INNER_CONST = 3'd0;
  localparam logic [2:0] IDX_INNER_CUBIC = 3'd1;
  localparam logic [2:0] IDX_OUTER_COEF  = 3'd2;
  localparam logic [2:0] IDX_SPHERE_NORM = 3'd3;

  localparam logic [REG_W-1:0] RST_INNER_CONST = 24'd166887;
  localparam logic [REG_W-1:0] RST_INNER_CUBIC = 24'd1001316;
  localparam logic [REG_W-1:0] RST_OUTER_COEF  = 24'd333772;
  localparam logic [REG_W-1:0] RST_SPHERE_NORM = 24'd274516;

  typedef struct packed {
    logic [REG_W-1:0] inner_constant;
    logic [REG_W-1:0] inner_cubic;
    logic [REG_W-1:0] outer_coefficient;
    logic [REG_W-1:0] sphere_norm;
  } kcfg_t;

  // One classified request, front to back.
  typedef struct packed {
    logic        hit;
    logic        last;
    logic [61:0] d2;
    logic [30:0] radius;
    logic [31:0] mass;
    logic [31:0] volume_ratio;
  } entry_t;

  typedef enum logic [1:0] {F_IDLE, F_SQ, F_RR, F_PUSH} front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_SQRT, B_DIV, B_M1, B_M2, B_M3, B_O1, B_O2, B_O3,
    B_NS, B_MT, B_VT, B_ACC
  } back_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sph_kernel_neighbour_sum_core.sv =====
// sph_kernel_neighbour_sum_core: top level, kernel register bank and front/queue/back hookup.
// Depends on sphkn_pkg, sphkn_front, sphkn_queue, sphkn_back.
//
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | centre, radius, neighbour position, mass, volume, flags
//  out     | out_valid/ out_stall | inside_count, weighted_mass, volume_weight
//  cfg     | cfg_we               | cfg_index (3b), cfg_wdata (24b)
//
// Front takes one request at a time (three squares and radius^2 on one multiplier).
// Back: an outside neighbour goes straight to accumulate; an inside one runs a 31-step sqrt,
// a 16-step divide, six multiplies on one shared multiplier, then accumulate.
// Synchronous active-low reset; sums start at zero, no clearing pass.
// A held result stalls only the back on the next last neighbour; the queue decouples the front.
`default_nettype none
module sph_kernel_neighbour_sum_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [2:0]                cfg_index,
  input  wire logic [23:0]               cfg_wdata,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [31:0]               in_centre_x,
  input  wire logic [31:0]               in_centre_y,
  input  wire logic [31:0]               in_centre_z,
  input  wire logic [30:0]               in_radius,
  input  wire logic [31:0]               in_other_x,
  input  wire logic [31:0]               in_other_y,
  input  wire logic [31:0]               in_other_z,
  input  wire logic [31:0]               in_other_mass,
  input  wire logic [31:0]               in_other_volume_ratio,
  input  wire logic                      in_usable,
  input  wire logic                      in_last_neighbour,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [10:0]                    out_inside_count,
  output logic [31:0]                    out_weighted_mass,
  output logic [31:0]                    out_volume_weight
);

  sphkn_pkg::kcfg_t  cfg_r;
  sphkn_pkg::entry_t push_data, rd_data;
  logic push_valid, push_ready, rd_valid, rd_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inner_constant    <= sphkn_pkg::RST_INNER_CONST;
      cfg_r.inner_cubic       <= sphkn_pkg::RST_INNER_CUBIC;
      cfg_r.outer_coefficient <= sphkn_pkg::RST_OUTER_COEF;
      cfg_r.sphere_norm       <= sphkn_pkg::RST_SPHERE_NORM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sphkn_pkg::IDX_INNER_CONST: cfg_r.inner_constant    <= cfg_wdata;
        sphkn_pkg::IDX_INNER_CUBIC: cfg_r.inner_cubic       <= cfg_wdata;
        sphkn_pkg::IDX_OUTER_COEF:  cfg_r.outer_coefficient <= cfg_wdata;
        sphkn_pkg::IDX_SPHERE_NORM: cfg_r.sphere_norm       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sphkn_front u_front (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_centre_x, .in_centre_y, .in_centre_z, .in_radius,
    .in_other_x, .in_other_y, .in_other_z, .in_other_mass,
    .in_other_volume_ratio, .in_usable, .in_last_neighbour,
    .push_valid, .push_ready, .push_data
  );

  sphkn_queue u_queue (
    .clk, .rst_n,
    .wr_valid (push_valid), .wr_ready (push_ready), .wr_data (push_data),
    .rd_valid, .rd_pop, .rd_data
  );

  sphkn_back u_back (
    .clk, .rst_n, .cfg (cfg_r),
    .rd_valid, .rd_pop, .rd_data,
    .out_valid, .out_stall, .out_inside_count, .out_weighted_mass, .out_volume_weight
  );

endmodule
`default_nettype wire

// ===== hw/rtl/sphkn_front.sv =====
// sphkn_front: accepts requests, forms the wrapped squared distance and the inside test.
// Depends on sphkn_pkg; feeds sphkn_queue.
`default_nettype none
module sphkn_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [31:0]          in_centre_x,
  input  wire logic [31:0]          in_centre_y,
  input  wire logic [31:0]          in_centre_z,
  input  wire logic [30:0]          in_radius,
  input  wire logic [31:0]          in_other_x,
  input  wire logic [31:0]          in_other_y,
  input  wire logic [31:0]          in_other_z,
  input  wire logic [31:0]          in_other_mass,
  input  wire logic [31:0]          in_other_volume_ratio,
  input  wire logic                 in_usable,
  input  wire logic                 in_last_neighbour,
  output logic                      push_valid,
  input  wire logic                 push_ready,
  output sphkn_pkg::entry_t         push_data
);

  function automatic logic [31:0] wrap_dist(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    if (d[31]) d = 32'd0 - d;
    return d;
  endfunction

  sphkn_pkg::front_state_t state_r, state_nxt;

  logic [30:0] rad_r;
  logic [31:0] mass_r, vr_r;
  logic        usable_r, last_r;
  logic [31:0] dx_r, dy_r, dz_r;
  logic [63:0] d2_r;
  logic [61:0] rr_r;
  logic [1:0]  sq_idx_r;
  logic [31:0] m_a;
  logic [63:0] prod;
  logic        accept;
  logic        hit;

  assign accept = in_valid && !in_stall;
  assign prod   = m_a * m_a;

  always_comb begin
    unique case (sq_idx_r)
      2'd0:    m_a = dx_r;
      2'd1:    m_a = dy_r;
      default: m_a = dz_r;
    endcase
    if (state_r == sphkn_pkg::F_RR) m_a = {1'b0, rad_r};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sphkn_pkg::F_IDLE: if (accept) state_nxt = sphkn_pkg::F_SQ;
      sphkn_pkg::F_SQ:   if (sq_idx_r == 2'd2) state_nxt = sphkn_pkg::F_RR;
      sphkn_pkg::F_RR:   state_nxt = sphkn_pkg::F_PUSH;
      sphkn_pkg::F_PUSH: if (push_ready) state_nxt = sphkn_pkg::F_IDLE;
      default:           state_nxt = sphkn_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    hit                    = usable_r && (rad_r != 31'd0) && (d2_r < {2'b00, rr_r});
    in_stall               = (state_r != sphkn_pkg::F_IDLE);
    push_valid             = (state_r == sphkn_pkg::F_PUSH);
    push_data.hit          = hit;
    push_data.last         = last_r;
    push_data.d2           = d2_r[61:0];
    push_data.radius       = rad_r;
    push_data.mass         = mass_r;
    push_data.volume_ratio = vr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sphkn_pkg::F_IDLE;
      sq_idx_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (accept) sq_idx_r <= 2'd0;
      else if (state_r == sphkn_pkg::F_SQ) sq_idx_r <= sq_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rad_r    <= in_radius;
      mass_r   <= in_other_mass;
      vr_r     <= in_other_volume_ratio;
      usable_r <= in_usable;
      last_r   <= in_last_neighbour;
      dx_r     <= wrap_dist(in_centre_x, in_other_x);
      dy_r     <= wrap_dist(in_centre_y, in_other_y);
      dz_r     <= wrap_dist(in_centre_z, in_other_z);
      d2_r     <= 64'd0;
    end else if (state_r == sphkn_pkg::F_SQ) begin
      d2_r <= d2_r + prod;
    end
    if (state_r == sphkn_pkg::F_RR) rr_r <= prod[61:0];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sphkn_queue.sv =====
// sphkn_queue: short register FIFO between front and back.
// Depends on sphkn_pkg for the entry type and depth.
`default_nettype none
module sphkn_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_valid,
  output logic                    wr_ready,
  input  wire sphkn_pkg::entry_t  wr_data,
  output logic                    rd_valid,
  input  wire logic               rd_pop,
  output sphkn_pkg::entry_t       rd_data
);

  sphkn_pkg::entry_t mem_r [sphkn_pkg::QDEPTH];
  logic [sphkn_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [sphkn_pkg::QCNT_W-1:0] cnt_r;
  logic push, pop;

  assign wr_ready = (cnt_r != sphkn_pkg::QCNT_W'(sphkn_pkg::QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == sphkn_pkg::QPTR_W'(sphkn_pkg::QDEPTH - 1)) ?
                            '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == sphkn_pkg::QPTR_W'(sphkn_pkg::QDEPTH - 1)) ?
                            '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sphkn_back.sv =====
// sphkn_back: per-neighbour sqrt, divide and kernel sequence, accumulators and result register.
// Depends on sphkn_pkg; drains sphkn_queue.
`default_nettype none
module sphkn_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire sphkn_pkg::kcfg_t                  cfg,
  input  wire logic                              rd_valid,
  output logic                                   rd_pop,
  input  wire sphkn_pkg::entry_t                 rd_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [sphkn_pkg::COUNT_W-1:0]          out_inside_count,
  output logic [31:0]                            out_weighted_mass,
  output logic [31:0]                            out_volume_weight
);

  localparam logic [sphkn_pkg::SUM_W-1:0] SumMax = '1;

  sphkn_pkg::back_state_t state_r, state_nxt;
  sphkn_pkg::entry_t      ent_r;

  logic [62:0] v_r, res_r;
  logic [4:0]  k_r;
  logic [31:0] rem_r;
  logic [15:0] q_r;
  logic [3:0]  dcnt_r;
  logic [15:0] u_r, uu_r;
  logic [16:0] t_r;
  logic [17:0] oo_r;
  logic [18:0] om3_r;
  logic [26:0] shape_r;
  logic [34:0] ns_r;
  logic [50:0] mterm_r;
  logic [42:0] vterm_r;

  logic [sphkn_pkg::COUNT_W-1:0] count_r;
  logic [sphkn_pkg::SUM_W-1:0]   msum_r, vsum_r;
  logic                          out_valid_r;
  logic [sphkn_pkg::COUNT_W-1:0] out_count_r;
  logic [31:0]                   out_mass_r, out_vol_r;

  logic [62:0] bit_v, trial;
  logic        sq_ge;
  logic [62:0] res_next, v_next;
  logic [31:0] rem2;
  logic        d_ge;
  logic [15:0] q_next;
  logic [16:0] om;
  logic [34:0] m_a, m_b;
  logic [69:0] prod;
  logic [24:0] sub;
  logic [51:0] msum_add, vsum_add;
  logic [sphkn_pkg::SUM_W-1:0]   msum_new, vsum_new;
  logic [sphkn_pkg::COUNT_W-1:0] count_new;
  logic        out_free;
  logic        take;

  // isqrt step: bit = 4^k
  assign bit_v    = 63'd1 << {k_r, 1'b0};
  assign trial    = res_r + bit_v;
  assign sq_ge    = (v_r >= trial);
  assign v_next   = sq_ge ? v_r - trial : v_r;
  assign res_next = sq_ge ? (res_r >> 1) + bit_v : res_r >> 1;

  // restoring divide step, remainder always below radius
  assign rem2   = {rem_r[30:0], 1'b0};
  assign d_ge   = (rem2 >= {1'b0, ent_r.radius});
  assign q_next = {q_r[14:0], d_ge};

  assign om   = 17'h10000 - {1'b0, u_r};
  assign prod = m_a * m_b;
  assign sub  = prod[40:16];

  assign out_free = !out_valid_r || !out_stall;
  assign take     = (state_r == sphkn_pkg::B_IDLE) && rd_valid;

  always_comb begin
    m_a = '0;
    m_b = '0;
    unique case (state_r)
      sphkn_pkg::B_M1: begin m_a = 35'(u_r);                   m_b = 35'(u_r);   end
      sphkn_pkg::B_M2: begin m_a = 35'(om);                    m_b = 35'(uu_r);  end
      sphkn_pkg::B_M3: begin m_a = 35'(cfg.inner_cubic);       m_b = 35'(t_r);   end
      sphkn_pkg::B_O1: begin m_a = 35'(om);                    m_b = 35'(om);    end
      sphkn_pkg::B_O2: begin m_a = 35'(oo_r);                  m_b = 35'(om);    end
      sphkn_pkg::B_O3: begin m_a = 35'(cfg.outer_coefficient); m_b = 35'(om3_r); end
      sphkn_pkg::B_NS: begin m_a = 35'(cfg.sphere_norm);       m_b = 35'(shape_r); end
      sphkn_pkg::B_MT: begin m_a = ns_r;                       m_b = 35'(ent_r.mass); end
      sphkn_pkg::B_VT: begin m_a = 35'(ent_r.volume_ratio);    m_b = 35'(shape_r); end
      default:         begin m_a = '0;                         m_b = '0;         end
    endcase
  end

  always_comb begin
    msum_add  = {4'd0, msum_r} + {1'b0, mterm_r};
    vsum_add  = {4'd0, vsum_r} + {9'd0, vterm_r};
    msum_new  = (msum_add > {4'd0, SumMax}) ? SumMax : msum_add[sphkn_pkg::SUM_W-1:0];
    vsum_new  = (vsum_add > {4'd0, SumMax}) ? SumMax : vsum_add[sphkn_pkg::SUM_W-1:0];
    count_new = (ent_r.hit && (count_r < sphkn_pkg::COUNT_CAP)) ? count_r + 1'b1 : count_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sphkn_pkg::B_IDLE: if (rd_valid)
                           state_nxt = rd_data.hit ? sphkn_pkg::B_SQRT : sphkn_pkg::B_ACC;
      sphkn_pkg::B_SQRT: if (k_r == 5'd0) state_nxt = sphkn_pkg::B_DIV;
      sphkn_pkg::B_DIV:  if (dcnt_r == 4'd0)
                           state_nxt = q_next[15] ? sphkn_pkg::B_O1 : sphkn_pkg::B_M1;
      sphkn_pkg::B_M1:   state_nxt = sphkn_pkg::B_M2;
      sphkn_pkg::B_M2:   state_nxt = sphkn_pkg::B_M3;
      sphkn_pkg::B_M3:   state_nxt = sphkn_pkg::B_NS;
      sphkn_pkg::B_O1:   state_nxt = sphkn_pkg::B_O2;
      sphkn_pkg::B_O2:   state_nxt = sphkn_pkg::B_O3;
      sphkn_pkg::B_O3:   state_nxt = sphkn_pkg::B_NS;
      sphkn_pkg::B_NS:   state_nxt = sphkn_pkg::B_MT;
      sphkn_pkg::B_MT:   state_nxt = sphkn_pkg::B_VT;
      sphkn_pkg::B_VT:   state_nxt = sphkn_pkg::B_ACC;
      sphkn_pkg::B_ACC:  if (!ent_r.last || out_free) state_nxt = sphkn_pkg::B_IDLE;
      default:           state_nxt = sphkn_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    rd_pop            = take;
    out_valid         = out_valid_r;
    out_inside_count  = out_count_r;
    out_weighted_mass = out_mass_r;
    out_volume_weight = out_vol_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sphkn_pkg::B_IDLE;
      count_r     <= '0;
      msum_r      <= '0;
      vsum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == sphkn_pkg::B_ACC) && ent_r.last && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == sphkn_pkg::B_ACC) begin
        if (!ent_r.last) begin
          count_r <= count_new;
          msum_r  <= msum_new;
          vsum_r  <= vsum_new;
        end else if (out_free) begin
          count_r <= '0;
          msum_r  <= '0;
          vsum_r  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ent_r   <= rd_data;
      v_r     <= {1'b0, rd_data.d2};
      res_r   <= '0;
      k_r     <= 5'd30;
      mterm_r <= '0;
      vterm_r <= '0;
    end
    unique case (state_r)
      sphkn_pkg::B_SQRT: begin
        v_r   <= v_next;
        res_r <= res_next;
        k_r   <= k_r - 5'd1;
        if (k_r == 5'd0) begin
          rem_r  <= res_next[31:0];
          q_r    <= '0;
          dcnt_r <= 4'd15;
        end
      end
      sphkn_pkg::B_DIV: begin
        rem_r  <= d_ge ? rem2 - {1'b0, ent_r.radius} : rem2;
        q_r    <= q_next;
        dcnt_r <= dcnt_r - 4'd1;
        if (dcnt_r == 4'd0) u_r <= q_next;
      end
      sphkn_pkg::B_M1: uu_r  <= prod[31:16];
      sphkn_pkg::B_M2: t_r   <= prod[32:16];
      sphkn_pkg::B_M3: shape_r <= (sub >= {1'b0, cfg.inner_constant}) ? 27'd0 :
                                  27'({1'b0, cfg.inner_constant} - sub);
      sphkn_pkg::B_O1: oo_r  <= prod[33:16];
      sphkn_pkg::B_O2: om3_r <= prod[34:16];
      sphkn_pkg::B_O3: shape_r <= prod[42:16];
      sphkn_pkg::B_NS: ns_r  <= prod[50:16];
      sphkn_pkg::B_MT: mterm_r <= prod[66:16];
      sphkn_pkg::B_VT: vterm_r <= prod[58:16];
      default: ;
    endcase
    if ((state_r == sphkn_pkg::B_ACC) && ent_r.last && out_free) begin
      out_count_r <= count_new;
      out_mass_r  <= (msum_new > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : msum_new[31:0];
      out_vol_r   <= (vsum_new > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : vsum_new[31:0];
    end
  end

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// testbench: self-checking bench for sph_kernel_neighbour_sum_core.
// Predicts the kernel density totals in a scoreboard class; needs sphkn_pkg and the core RTL.
`default_nettype none
module testbench;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [31:0] cx, cy, cz;
    logic [30:0] rad;
    logic [31:0] ox, oy, oz, mass, vr;
    logic        usable, last;
  } cand_t;

  typedef struct packed {
    logic [10:0] cnt;
    logic [31:0] wmass, vweight;
  } totals_t;

  class density_board;
    logic [23:0] c1, c2, c5, nrm;
    logic [63:0] cnt, msum, vsum;
    totals_t     pending[$];
    int          errors;
    int          checked;

    function new();
      c1 = sphkn_pkg::RST_INNER_CONST; c2 = sphkn_pkg::RST_INNER_CUBIC;
      c5 = sphkn_pkg::RST_OUTER_COEF;  nrm = sphkn_pkg::RST_SPHERE_NORM;
      cnt = 0; msum = 0; vsum = 0; errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] v);
      case (idx)
        sphkn_pkg::IDX_INNER_CONST: c1 = v;
        sphkn_pkg::IDX_INNER_CUBIC: c2 = v;
        sphkn_pkg::IDX_OUTER_COEF:  c5 = v;
        sphkn_pkg::IDX_SPHERE_NORM: nrm = v;
        default: ;
      endcase
    endfunction

    function logic [63:0] wrap(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d >= 32'h8000_0000) ? (64'h1_0000_0000 - 64'(d)) : 64'(d);
    endfunction

    function logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function logic [63:0] sat48(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : s;
    endfunction

    function void note(cand_t c);
      logic [63:0] dx, dy, dz, d2, r, u, om, t, sub, shape, ns, rad;
      totals_t tot;
      rad = 64'(c.rad);
      if (c.usable && rad != 0) begin
        dx = wrap(c.cx, c.ox); dy = wrap(c.cy, c.oy); dz = wrap(c.cz, c.oz);
        d2 = dx * dx + dy * dy + dz * dz;
        if (d2 < rad * rad) begin
          r = isqrt(d2);
          u = (r << 16) / rad;
          if (u > 65535) u = 65535;
          om = 65536 - u;
          if (u < 32768) begin
            t = (om * ((u * u) >> 16)) >> 16;
            sub = (64'(c2) * t) >> 16;
            shape = (sub >= 64'(c1)) ? 0 : 64'(c1) - sub;
          end else begin
            t = (((om * om) >> 16) * om) >> 16;
            shape = (64'(c5) * t) >> 16;
          end
          ns = (64'(nrm) * shape) >> 16;
          if (cnt < 64'(sphkn_pkg::COUNT_CAP)) cnt = cnt + 1;
          msum = sat48(msum, (ns * 64'(c.mass)) >> 16);
          vsum = sat48(vsum, (64'(c.vr) * shape) >> 16);
        end
      end
      if (c.last) begin
        tot.cnt = cnt[10:0];
        tot.wmass = (msum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : msum[31:0];
        tot.vweight = (vsum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : vsum[31:0];
        pending.push_back(tot);
        cnt = 0; msum = 0; vsum = 0;
      end
    endfunction

    function void check(totals_t got);
      totals_t want;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result cnt=%0d wm=%h vw=%h", $time, got.cnt,
                 got.wmass, got.vweight);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.cnt != want.cnt) begin
        $display("%0t: inside_count expected %0d actual %0d", $time, want.cnt, got.cnt);
        errors++;
      end
      if (got.wmass != want.wmass) begin
        $display("%0t: weighted_mass expected %h actual %h", $time, want.wmass, got.wmass);
        errors++;
      end
      if (got.vweight != want.vweight) begin
        $display("%0t: volume_weight expected %h actual %h", $time, want.vweight,
                 got.vweight);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0, rst_n = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = 0;
  logic [23:0] cfg_wdata = 0;
  logic        in_valid = 0, out_stall = 0;
  cand_t       req = '0;
  logic        in_stall, out_valid;
  logic [10:0] out_inside_count;
  logic [31:0] out_weighted_mass, out_volume_weight;

  density_board sb = new();
  int send_idle_pct = 33, recv_stall_pct = 47;
  int cycles = 0;
  int items_sent = 0;

  sph_kernel_neighbour_sum_core dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall,
    .in_centre_x(req.cx), .in_centre_y(req.cy), .in_centre_z(req.cz),
    .in_radius(req.rad),
    .in_other_x(req.ox), .in_other_y(req.oy), .in_other_z(req.oz),
    .in_other_mass(req.mass), .in_other_volume_ratio(req.vr),
    .in_usable(req.usable), .in_last_neighbour(req.last),
    .out_valid, .out_stall,
    .out_inside_count, .out_weighted_mass, .out_volume_weight
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // monitors: sampled at the edge, before the core updates
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note(req);
    if (rst_n && out_valid && !out_stall)
      sb.check({out_inside_count, out_weighted_mass, out_volume_weight});
  end

  // receiver, with one long hold-off so the queue fills and the input stalls
  initial begin
    int hold;
    logic held;
    held = 0;
    forever begin
      @(negedge clk);
      if (!held && sb.checked == 30) begin
        held = 1;
        out_stall <= 1;
        for (hold = 0; hold < 600; hold++) @(negedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send(cand_t c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    req <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] v);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, v);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic cand_t mk(logic [31:0] cx, logic [31:0] ox, logic [30:0] rad,
                               logic [31:0] mass, logic [31:0] vr, logic usable,
                               logic last);
    cand_t c;
    c.cx = cx; c.cy = cx; c.cz = cx;
    c.ox = ox; c.oy = ox; c.oz = ox;
    c.rad = rad; c.mass = mass; c.vr = vr; c.usable = usable; c.last = last;
    return c;
  endfunction

  function automatic logic [31:0] near(logic [31:0] ctr, logic [30:0] rad);
    logic [32:0] span;
    span = {2'b0, rad};
    return ctr + 32'($urandom_range(0, 32'(2 * span))) - 32'(span);
  endfunction

  // one target: centre and radius held unless broken, neighbours mostly around it
  task automatic random_target(int len, logic broken);
    cand_t c;
    int i, k;
    logic [31:0] cx, cy, cz;
    logic [30:0] rad;
    cx = $urandom; cy = $urandom; cz = $urandom;
    k = $urandom_range(9);
    if (k == 0) rad = 31'($urandom_range(1, 16));
    else if (k == 1) rad = 31'($urandom);
    else if (k == 2) rad = 0;
    else rad = 31'($urandom) >> $urandom_range(1, 24);
    for (i = 0; i < len; i++) begin
      c.cx = cx; c.cy = cy; c.cz = cz; c.rad = rad;
      if ($urandom_range(9) < 8) begin
        c.ox = near(cx, rad); c.oy = near(cy, rad); c.oz = near(cz, rad);
      end else begin
        c.ox = $urandom; c.oy = $urandom; c.oz = $urandom;
      end
      c.mass = ($urandom_range(15) == 0) ? 32'hFFFF_FFFF : $urandom;
      c.vr = ($urandom_range(15) == 0) ? 32'hFFFF_FFFF : $urandom;
      c.usable = ($urandom_range(9) != 0);
      c.last = broken ? ($urandom_range(3) == 0) : (i == len - 1);
      if (broken) begin
        c.cx = $urandom; c.rad = 31'($urandom) >> $urandom_range(0, 30);
      end
      send(c);
    end
  endtask

  task automatic random_phase(int n);
    int stop;
    stop = items_sent + n;
    while (items_sent < stop)
      random_target($urandom_range(1, 12), $urandom_range(9) == 0);
  endtask

  initial begin
    int p, i;
    repeat (12) @(negedge clk);
    rst_n <= 1;

    // directed: center hit, wraparound, unusable, zero radius, half radius, outside the radius
    send(mk(32'h0, 32'h0, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0));
    send(mk(32'h0, 32'hFFFF_FFFF, 31'd4, 32'h0001_0000, 32'h0001_0000, 1, 0));
    send(mk(32'h10, 32'h10, 31'd100, 32'h0001_0000, 32'h0001_0000, 0, 0));
    send(mk(32'h10, 32'h10, 31'd0, 32'h0001_0000, 32'h0001_0000, 1, 1));
    send(mk(32'd1000, 32'd1289, 31'd1000, 32'h0002_0000, 32'h0003_0000, 1, 1));
    send(mk(32'd0, 32'd1000, 31'd1000, 32'h0002_0000, 32'h0003_0000, 1, 0));
    send(mk(32'd5, 32'd5, 31'd1000, 32'h0002_0000, 32'h0003_0000, 0, 1));
    send(mk(32'h0, 32'h8000_0000, 31'h7FFF_FFFF, 32'h0, 32'h0, 1, 1));
    send(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 1, 1));
    send(mk(32'h7FFF_FFF0, 32'h8000_0010, 31'd64, 32'hFFFF_FFFF, 32'h1, 1, 1));
    random_phase(150);
    drain();

    for (p = 1; p < 5; p++) begin
      if (p == 2) begin
        send_idle_pct = 47; recv_stall_pct = 33;
      end else if (p == 4) begin
        send_idle_pct = 0; recv_stall_pct = 0;
      end
      case (p)
        1: begin
          for (i = 0; i < 4; i++) write_reg(3'(i), 24'hFF_FFFF);
          for (i = 4; i < 8; i++) write_reg(3'(i), 24'($urandom));
          // both sums pushed past their limits
          send(mk(32'h0, 32'h0, 31'd50, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0));
          send(mk(32'h0, 32'h0, 31'd50, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1));
        end
        2: for (i = 0; i < 4; i++) write_reg(3'(i), 24'h0);
        3: for (i = 0; i < 4; i++) write_reg(3'(i), 24'($urandom));
        default: begin
          write_reg(sphkn_pkg::IDX_INNER_CONST, sphkn_pkg::RST_INNER_CONST);
          write_reg(sphkn_pkg::IDX_INNER_CUBIC, sphkn_pkg::RST_INNER_CUBIC);
          write_reg(sphkn_pkg::IDX_OUTER_COEF, sphkn_pkg::RST_OUTER_COEF);
          write_reg(sphkn_pkg::IDX_SPHERE_NORM, sphkn_pkg::RST_SPHERE_NORM);
          // count saturation: more inside neighbours than the cap
          for (i = 0; i < sphkn_pkg::MAX_NEIGHBOURS + 6; i++)
            send(mk(32'd500, 32'd500 + 32'($urandom_range(0, 40)), 31'd100,
                    $urandom, $urandom, 1, i == sphkn_pkg::MAX_NEIGHBOURS + 5));
        end
      endcase
      random_phase(160);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
